// File: sv/caldc_pkg.sv
package caldc_pkg;

  localparam int DAY_W  = 5;
  localparam int MON_W  = 4;
  localparam int YEAR_W = 14;

  localparam logic [YEAR_W-1:0] YEAR_TOP   = 14'd9999;
  localparam logic [YEAR_W-1:0] YEAR_FIRST = 14'd1;

  // reset values
  localparam logic [YEAR_W-1:0] MIN_YEAR_RST = 14'd1902;
  localparam logic [YEAR_W-1:0] MAX_YEAR_RST = 14'd2037;
  localparam logic [4:0]        MOD25_RST    = 5'd2;   // 1902 mod 25

  // reciprocal constants: floor(x / n) == (x * RECIP) >> SHIFT for 14/15-bit x
  localparam int RECIP25   = 20972;
  localparam int SHIFT25   = 19;
  localparam int RECIP100  = 5243;
  localparam int SHIFT100  = 19;
  localparam int RECIP7    = 18725;
  localparam int SHIFT7    = 17;

  typedef enum logic [1:0] {
    FN_LOAD = 2'd0,
    FN_NEXT = 2'd1,
    FN_PREV = 2'd2,
    FN_CMP  = 2'd3
  } func_t;

  typedef enum logic {
    REG_MIN_YEAR = 1'b0,
    REG_MAX_YEAR = 1'b1
  } reg_idx_t;

  // day in the low bits, so the struct matches the beat layout
  typedef struct packed {
    logic [YEAR_W-1:0] year;
    logic [MON_W-1:0]  month;
    logic [DAY_W-1:0]  day;
  } date_t;

  typedef struct packed {
    date_t date;
    logic  err;
    logic  is_before;
    logic  is_after;
  } res_t;

  function automatic logic [DAY_W-1:0] month_days(input logic [MON_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] n;
    unique case (m)
      4'd2:                   n = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: n = 5'd30;
      default:                n = 5'd31;
    endcase
    return n;
  endfunction

  // floor(31 * mm / 12), mm being the month counted from March
  function automatic logic [4:0] month_offset(input logic [MON_W-1:0] m);
    logic [4:0] o;
    unique case (m)
      4'd1:    o = 5'd28;
      4'd2:    o = 5'd31;
      4'd3:    o = 5'd2;
      4'd4:    o = 5'd5;
      4'd5:    o = 5'd7;
      4'd6:    o = 5'd10;
      4'd7:    o = 5'd12;
      4'd8:    o = 5'd15;
      4'd9:    o = 5'd18;
      4'd10:   o = 5'd20;
      4'd11:   o = 5'd23;
      4'd12:   o = 5'd25;
      default: o = 5'd0;
    endcase
    return o;
  endfunction

endpackage

// File: sv/calendar_date_counter.sv
// Gregorian date counter.
// Input beats (in_*): in_tuser carries the operation (load, next day, previous
// day, compare), in_tdata the day, month and year used by load and compare.
// Output beats (out_*): exactly one per input beat, in order, carrying the held
// date after the operation, its weekday (0 = Sunday), the error flag (refused
// load or refused step) and the before/after flags of a compare.
// cfg_*: write-only year window for loads; write only while the block is idle.
// Pipeline: input register, execute (date register update), two weekday
// stages, output register. Throughput is one beat per cycle while the output
// is not stalled; the weekday path is set by the two reciprocal multiplies
// (divide by 100, modulo 7), each on a stage of its own.
// Leap years are tracked through a year-mod-25 register beside the held date,
// so stepping never needs a divider in the feedback loop.
// Reset (rst_n low, synchronous): date 1 January 1902, year window 1902..2037,
// pipeline empty.
// Stall: the whole pipeline holds while out_tvalid is high and out_tready low;
// in_tready then drops in the same cycle, so no beat is lost or repeated.
module calendar_date_counter (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [23:0]                 in_tdata,   // day[4:0] month[8:5] year[22:9] zero
  input  logic [1:0]                  in_tuser,   // func[1:0]
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [31:0]                 out_tdata,  // day[4:0] month[8:5] year[22:9]
                                                  // weekday[25:23] error[26]
                                                  // is_before[27] is_after[28] zero
  input  logic                        cfg_wr_en,
  input  logic                        cfg_addr,
  input  logic [caldc_pkg::YEAR_W-1:0] cfg_wdata
);
  import caldc_pkg::*;

  // ---------------------------------------------------------------- control
  logic adv;                 // whole pipeline moves on
  logic in_valid_r, ex_valid_r, a_valid_r, b_valid_r, out_valid_r;

  assign adv       = !out_valid_r || out_tready;
  assign in_tready = adv;

  // ---------------------------------------------------------------- config
  logic [YEAR_W-1:0] min_year_r, max_year_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_year_r <= MIN_YEAR_RST;
      max_year_r <= MAX_YEAR_RST;
    end else if (cfg_wr_en) begin
      unique case (reg_idx_t'(cfg_addr))
        REG_MIN_YEAR: min_year_r <= cfg_wdata;
        REG_MAX_YEAR: max_year_r <= cfg_wdata;
      endcase
    end
  end

  // ---------------------------------------------------------------- input stage
  // Year mod 25 and the leap flag of the given year are worked out here.
  date_t             in_date;
  logic [28:0]       in_p25;
  logic [9:0]        in_q25;
  logic [YEAR_W-1:0] in_diff25;
  logic [4:0]        in_mod25;
  logic              in_leap;

  assign in_date   = date_t'(in_tdata[22:0]);
  assign in_p25    = 29'(in_date.year) * 29'(RECIP25);
  assign in_q25    = in_p25[28:SHIFT25];
  assign in_diff25 = in_date.year - YEAR_W'(14'(in_q25) * 14'd25);
  assign in_mod25  = in_diff25[4:0];
  assign in_leap   = (in_date.year[1:0] == 2'd0) &&
                     ((in_mod25 != 5'd0) || (in_date.year[3:0] == 4'd0));

  func_t      in_func_r;
  date_t      in_date_r;
  logic       in_leap_r;
  logic [4:0] in_mod25_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      in_func_r  <= func_t'(in_tuser);
      in_date_r  <= in_date;
      in_leap_r  <= in_leap;
      in_mod25_r <= in_mod25;
    end
  end

  // ---------------------------------------------------------------- execute
  date_t      cur_r, cur_nxt;
  logic [4:0] cur_mod25_r, cur_mod25_nxt;
  logic       cur_leap;
  logic [DAY_W-1:0] dim_cur, dim_prev, dim_in;
  logic [MON_W-1:0] prev_month;
  logic       load_ok;
  logic       err_nxt, before_nxt, after_nxt;

  assign cur_leap   = (cur_r.year[1:0] == 2'd0) &&
                      ((cur_mod25_r != 5'd0) || (cur_r.year[3:0] == 4'd0));
  assign prev_month = cur_r.month - 4'd1;
  assign dim_cur    = month_days(cur_r.month, cur_leap);
  assign dim_prev   = month_days(prev_month, cur_leap);
  assign dim_in     = month_days(in_date_r.month, in_leap_r);

  assign load_ok = (in_date_r.month >= 4'd1) && (in_date_r.month <= 4'd12) &&
                   (in_date_r.year >= YEAR_FIRST) && (in_date_r.year <= YEAR_TOP) &&
                   (in_date_r.year >= min_year_r) && (in_date_r.year <= max_year_r) &&
                   (in_date_r.day != 5'd0) && (in_date_r.day <= dim_in);

  always_comb begin
    cur_nxt       = cur_r;
    cur_mod25_nxt = cur_mod25_r;
    err_nxt       = 1'b0;
    before_nxt    = 1'b0;
    after_nxt     = 1'b0;
    unique case (in_func_r)
      FN_LOAD: begin
        if (load_ok) begin
          cur_nxt       = in_date_r;
          cur_mod25_nxt = in_mod25_r;
        end else begin
          err_nxt = 1'b1;
        end
      end
      FN_NEXT: begin
        if (cur_r.day == dim_cur) begin
          if (cur_r.month == 4'd12) begin
            if (cur_r.year >= YEAR_TOP) begin
              err_nxt = 1'b1;
            end else begin
              cur_nxt.year  = cur_r.year + 14'd1;
              cur_nxt.month = 4'd1;
              cur_nxt.day   = 5'd1;
              cur_mod25_nxt = (cur_mod25_r == 5'd24) ? 5'd0 : cur_mod25_r + 5'd1;
            end
          end else begin
            cur_nxt.month = cur_r.month + 4'd1;
            cur_nxt.day   = 5'd1;
          end
        end else begin
          cur_nxt.day = cur_r.day + 5'd1;
        end
      end
      FN_PREV: begin
        if (cur_r.day == 5'd1) begin
          if (cur_r.month == 4'd1) begin
            if (cur_r.year <= YEAR_FIRST) begin
              err_nxt = 1'b1;
            end else begin
              cur_nxt.year  = cur_r.year - 14'd1;
              cur_nxt.month = 4'd12;
              cur_nxt.day   = 5'd31;
              cur_mod25_nxt = (cur_mod25_r == 5'd0) ? 5'd24 : cur_mod25_r - 5'd1;
            end
          end else begin
            cur_nxt.month = prev_month;
            cur_nxt.day   = dim_prev;
          end
        end else begin
          cur_nxt.day = cur_r.day - 5'd1;
        end
      end
      FN_CMP: begin
        // raw fields, year first: the packed struct orders them so
        before_nxt = cur_r < in_date_r;
        after_nxt  = cur_r > in_date_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r       <= '{year: MIN_YEAR_RST, month: 4'd1, day: 5'd1};
      cur_mod25_r <= MOD25_RST;
    end else if (adv && in_valid_r) begin
      cur_r       <= cur_nxt;
      cur_mod25_r <= cur_mod25_nxt;
    end
  end

  res_t ex_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      ex_r <= '{date: cur_nxt, err: err_nxt, is_before: before_nxt, is_after: after_nxt};
    end
  end

  // ---------------------------------------------------------------- weekday A
  // January and February count as months 11 and 12 of the year before.
  logic              a_k;
  logic [YEAR_W-1:0] a_yy;
  res_t              a_res_r;
  logic [YEAR_W-1:0] a_yy_r;
  logic [26:0]       a_p100_r;
  logic [4:0]        a_off_r;

  assign a_k  = (ex_r.date.month <= 4'd2);
  assign a_yy = ex_r.date.year - YEAR_W'(a_k);

  always_ff @(posedge clk) begin
    if (adv) begin
      a_res_r  <= ex_r;
      a_yy_r   <= a_yy;
      a_p100_r <= 27'(a_yy) * 27'(RECIP100);
      a_off_r  <= month_offset(ex_r.date.month);
    end
  end

  // ---------------------------------------------------------------- weekday B
  logic [7:0]  b_q100;
  logic [14:0] b_sum;
  res_t        b_res_r;
  logic [14:0] b_sum_r;
  logic [29:0] b_p7_r;

  assign b_q100 = a_p100_r[26:SHIFT100];
  assign b_sum  = 15'(a_res_r.date.day) + 15'(a_yy_r) + 15'(a_yy_r >> 2)
                - 15'(b_q100) + 15'(b_q100 >> 2) + 15'(a_off_r);

  always_ff @(posedge clk) begin
    if (adv) begin
      b_res_r <= a_res_r;
      b_sum_r <= b_sum;
      b_p7_r  <= 30'(b_sum) * 30'(RECIP7);
    end
  end

  // ---------------------------------------------------------------- output
  logic [12:0] o_q7;
  logic [14:0] o_rem;
  res_t        out_res_r;
  logic [2:0]  out_wd_r;

  assign o_q7  = b_p7_r[29:SHIFT7];
  assign o_rem = b_sum_r - 15'(15'(o_q7) * 15'd7);

  always_ff @(posedge clk) begin
    if (adv) begin
      out_res_r <= b_res_r;
      out_wd_r  <= o_rem[2:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      ex_valid_r  <= 1'b0;
      a_valid_r   <= 1'b0;
      b_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      in_valid_r  <= in_tvalid;
      ex_valid_r  <= in_valid_r;
      a_valid_r   <= ex_valid_r;
      b_valid_r   <= a_valid_r;
      out_valid_r <= b_valid_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_res_r.is_after, out_res_r.is_before, out_res_r.err,
                       out_wd_r, out_res_r.date.year, out_res_r.date.month,
                       out_res_r.date.day};

  // ---------------------------------------------------------------- checks
  held_year_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cur_r.year >= YEAR_FIRST) && (cur_r.year <= YEAR_TOP))
    else $error("held year left 1..9999");

  held_date_sane: assert property (@(posedge clk) disable iff (!rst_n)
    (cur_r.day != 5'd0) && (cur_r.month != 4'd0) && (cur_r.month <= 4'd12) &&
    (cur_mod25_r <= 5'd24))
    else $error("held date or year-mod-25 out of range");

  hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(cur_r) && $stable(cur_mod25_r))
    else $error("held date moved during a stall");

  flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_res_r.is_before && out_res_r.is_after) &&
                    !(out_res_r.err && (out_res_r.is_before || out_res_r.is_after)))
    else $error("result flags conflict");

endmodule
